FILE: design/isp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isp_pkg
// Shared types and constants of the interpolating sample player.
// ----------------------------------------------------------------------------
package isp_pkg;

   localparam int MAX_FRAMES_DEF  = 65536;
   localparam int SAMPLE_BITS_DEF = 16;

   // Phase format: unsigned Q1.24
   localparam logic [24:0] ONE_Q24    = 25'h1000000;
   localparam logic [24:0] MIN_SPAN   = 25'd16;
   localparam logic [15:0] UNITY_GAIN = 16'd4096;

   // Shared divider widths
   localparam int DVD_W = 48;
   localparam int DVS_W = 30;
   // Internal frame count width (covers the largest memory depth)
   localparam int FRM_W = 22;

   // Configuration register indexes
   localparam logic [1:0] CSR_FRAME_COUNT = 2'd0;
   localparam logic [1:0] CSR_RATE_RATIO  = 2'd1;
   localparam logic [1:0] CSR_STEREO      = 2'd2;
   localparam logic [1:0] CSR_GAIN        = 2'd3;

   // Request kinds
   localparam logic CMD_TICK  = 1'b0;
   localparam logic CMD_WRITE = 1'b1;

   // Transport modes
   localparam logic [2:0] MODE_STOP = 3'd1;
   localparam logic [2:0] MODE_LOOP = 3'd3;
   localparam logic [2:0] MODE_ONCE = 3'd5;
   localparam logic [2:0] MODE_NONE = 3'd7;

   typedef enum logic [4:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SETUP,
      ST_MUL,
      ST_INC_GO,
      ST_INC_WAIT,
      ST_POS_GO,
      ST_POS_WAIT,
      ST_IDX,
      ST_RD0,
      ST_RD1,
      ST_RD2,
      ST_INTL,
      ST_INTR,
      ST_GAINL,
      ST_GAINR,
      ST_PHASE,
      ST_WRAP_WAIT,
      ST_OUT
   } state_type;

endpackage

FILE: design/interpolating_sample_player_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// interpolating_sample_player_top
// Sample playback voice with linear interpolation, gain and transport modes.
// ----------------------------------------------------------------------------
// Response: a write request answers in the cycle after it is taken; a tick request
// runs up to three passes of the shared divider (increment, bounded phase,
// loop wrap) plus reads and multiplies.
// Throughput: one request at a time; the next is taken once the response left.
// Reset: synchronous; afterwards a clearing pass zeroes both sample memories
// before the first request is taken.
module interpolating_sample_player_top #(
   parameter int MAX_FRAMES  = isp_pkg::MAX_FRAMES_DEF,
   parameter int SAMPLE_BITS = isp_pkg::SAMPLE_BITS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   // request channel
   input  logic         req_tvalid,
   output logic         req_tready,
   // sample_index, sample_left, sample_right, reset_level, speed, phase_cv,
   // phase_connected, transport, range_start, range_end, phase_shift, zero pad
   input  logic [183:0] req_tdata,
   input  logic         req_tuser,   // cmd
   // response channel
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // left_out, right_out, mix_out, position, zero pad
   output logic [79:0]  rsp_tdata,
   output logic         rsp_tlast,   // end_pulse
   // configuration port
   input  logic         csr_we,
   input  logic [1:0]   csr_addr,
   input  logic [20:0]  csr_wdata
);

   localparam int AW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
   localparam int FW = isp_pkg::FRM_W;
   localparam logic signed [21:0] SAT_HI = 22'((1 << (SAMPLE_BITS - 1)) - 1);
   localparam logic signed [21:0] SAT_LO = -SAT_HI - 22'sd1;

   // ---------------- configuration registers ----------------
   logic [16:0] frame_count_ff;
   logic [20:0] rate_ratio_ff;
   logic        stereo_ff;
   logic [15:0] gain_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_count_ff <= '0;
         rate_ratio_ff  <= 21'd65536;
         stereo_ff      <= 1'b0;
         gain_ff        <= isp_pkg::UNITY_GAIN;
      end else if (csr_we) begin
         unique case (csr_addr)
            isp_pkg::CSR_FRAME_COUNT: frame_count_ff <= csr_wdata[16:0];
            isp_pkg::CSR_RATE_RATIO:  rate_ratio_ff  <= csr_wdata;
            isp_pkg::CSR_STEREO:      stereo_ff      <= csr_wdata[0];
            isp_pkg::CSR_GAIN:        gain_ff        <= csr_wdata[15:0];
            default:                  ;
         endcase
      end
   end

   // ---------------- latched request ----------------
   logic               req_acc;
   logic               in_rst_ff;
   logic signed [25:0] in_speed_ff;
   logic [24:0]        in_cv_ff;
   logic               in_conn_ff;
   logic [2:0]         in_mode_ff;
   logic [24:0]        in_rs_ff;
   logic [24:0]        in_re_ff;
   logic signed [27:0] in_shift_ff;

   assign req_acc = req_tvalid && req_tready;

   // Hold request fields; clamp transport above play once
   always_ff @(posedge clock) begin
      if (req_acc) begin
         in_rst_ff   <= req_tdata[48];
         in_speed_ff <= req_tdata[74:49];
         in_cv_ff    <= req_tdata[99:75];
         in_conn_ff  <= req_tdata[100];
         in_mode_ff  <= (req_tdata[103:101] > isp_pkg::MODE_ONCE) ? isp_pkg::MODE_ONCE
                                                                   : req_tdata[103:101];
         in_rs_ff    <= req_tdata[128:104];
         in_re_ff    <= req_tdata[153:129];
         in_shift_ff <= req_tdata[181:154];
      end
   end

   // ---------------- state ----------------
   isp_pkg::state_type state_ff, state_in;
   logic [AW-1:0] clr_addr_ff, clr_addr_in;

   logic [24:0] play_phase_ff, play_phase_in;
   logic        prev_reset_ff, prev_reset_in;
   logic [2:0]  prev_mode_ff, prev_mode_in;
   logic        finished_ff, finished_in;
   logic        range_seen_ff, range_seen_in;
   logic [24:0] prev_start_ff, prev_start_in;
   logic [24:0] prev_end_ff, prev_end_in;

   logic [24:0]        start_ff, start_in;
   logic [24:0]        end_ff, end_in;
   logic [24:0]        span_ff, span_in;
   logic               playing_ff, playing_in;
   logic [FW-1:0]      frames_ff, frames_in;
   logic signed [46:0] prod_ff, prod_in;
   logic signed [40:0] inc_ff, inc_in;
   logic [24:0]        base_ff, base_in;
   logic signed [40:0] x_ff, x_in;
   logic [24:0]        bounded_ff, bounded_in;
   logic [46:0]        idx_ff, idx_in;
   logic [AW-1:0]      i1_ff, i1_in;
   logic [23:0]        t_ff, t_in;
   logic signed [15:0] s0l_ff, s0l_in, s0r_ff, s0r_in, s1l_ff, s1l_in, s1r_ff, s1r_in;
   logic signed [40:0] lv_ff, lv_in, rv_ff, rv_in;
   logic signed [15:0] l_ff, l_in, r_ff, r_in;
   logic               done_ff, done_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [79:0] rsp_data_ff, rsp_data_in;
   logic        rsp_last_ff, rsp_last_in;

   // ---------------- sample memories ----------------
   logic signed [15:0] left_mem [MAX_FRAMES];
   logic signed [15:0] right_mem [MAX_FRAMES];
   logic signed [15:0] rdl_ff, rdr_ff;
   logic               mem_we;
   logic [AW-1:0]      mem_waddr;
   logic signed [15:0] mem_wl, mem_wr;
   logic [AW-1:0]      mem_raddr;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         left_mem[mem_waddr]  <= mem_wl;
         right_mem[mem_waddr] <= mem_wr;
      end
      rdl_ff <= left_mem[mem_raddr];
      rdr_ff <= right_mem[mem_raddr];
   end

   // ---------------- shared divider ----------------
   logic                      div_start;
   logic [isp_pkg::DVD_W-1:0] div_dvd;
   logic [isp_pkg::DVS_W-1:0] div_dvs;
   logic                      div_done;
   logic [isp_pkg::DVD_W-1:0] div_quo;
   logic [isp_pkg::DVS_W-1:0] div_rem;

   isp_div #(
      .DVD_W(isp_pkg::DVD_W),
      .DVS_W(isp_pkg::DVS_W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dvd),
      .divisor   (div_dvs),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   // ---------------- helper logic ----------------
   logic [24:0]        ca, cb, dab, s_start, s_end;
   logic [FW-1:0]      frames_cl, frm_m1;
   logic signed [40:0] x_pos, next_ph, x_wrap;
   logic [24:0]        base_sel, cv_cl, rmod, wrap_ph;
   logic [45:0]        maxi;
   logic [46:0]        idx_cl;
   logic [22:0]        i0, i0p1;
   logic signed [16:0] dl;
   logic signed [41:0] interp;
   logic signed [40:0] gsrc;
   logic signed [16:0] geff;
   logic signed [57:0] gprod;
   logic signed [21:0] gsh, gsat;
   logic [24:0]        mod_res;
   logic signed [16:0] mix_sum;
   logic [15:0]        mix_val;

   // Range: clamp, sort, whole buffer when nearly empty
   assign ca  = (in_rs_ff > isp_pkg::ONE_Q24) ? isp_pkg::ONE_Q24 : in_rs_ff;
   assign cb  = (in_re_ff > isp_pkg::ONE_Q24) ? isp_pkg::ONE_Q24 : in_re_ff;
   assign dab = (cb > ca) ? cb - ca : ca - cb;
   assign s_start = (dab <= isp_pkg::MIN_SPAN) ? '0 : ((ca < cb) ? ca : cb);
   assign s_end   = (dab <= isp_pkg::MIN_SPAN) ? isp_pkg::ONE_Q24 : ((ca < cb) ? cb : ca);

   assign frames_cl = ({5'd0, frame_count_ff} > FW'(MAX_FRAMES)) ? FW'(MAX_FRAMES)
                                                                 : {5'd0, frame_count_ff};
   assign frm_m1 = frames_ff - 1'b1;
   assign cv_cl  = (in_cv_ff > isp_pkg::ONE_Q24) ? isp_pkg::ONE_Q24 : in_cv_ff;

   // Readout base and offset phase
   assign base_sel = in_conn_ff ? cv_cl : play_phase_ff;
   assign x_pos    = $signed({16'd0, base_sel}) + 41'(in_shift_ff)
                   - $signed({16'd0, start_ff});
   assign next_ph  = $signed({16'd0, base_ff}) + inc_ff;
   assign x_wrap   = next_ph - $signed({16'd0, start_ff});

   // Floor modulo from the divider remainder
   assign rmod    = div_rem[24:0];
   assign mod_res = (x_ff < 0 && rmod != '0) ? 25'(start_ff + span_ff - rmod)
                                             : 25'(start_ff + rmod);
   assign wrap_ph = mod_res;

   // Frame index and fraction
   assign maxi   = {frm_m1, 24'd0};
   assign idx_cl = (idx_ff > {1'b0, maxi}) ? {1'b0, maxi} : idx_ff;
   assign i0     = idx_cl[46:24];
   assign i0p1   = i0 + 1'b1;

   // Shared interpolation multiplier
   always_comb begin
      if (state_ff == isp_pkg::ST_INTL) begin
         dl = 17'(s1l_ff) - 17'(s0l_ff);
         interp = (42'(s0l_ff) <<< 24) + dl * $signed({1'b0, t_ff});
      end else begin
         dl = 17'(s1r_ff) - 17'(s0r_ff);
         interp = (42'(s0r_ff) <<< 24) + dl * $signed({1'b0, t_ff});
      end
   end

   // Shared gain multiplier, round half up, saturate
   assign gsrc  = (state_ff == isp_pkg::ST_GAINL) ? lv_ff : rv_ff;
   assign geff  = gain_ff[15] ? $signed({1'b0, isp_pkg::UNITY_GAIN})
                              : $signed({1'b0, gain_ff});
   assign gprod = gsrc * geff;
   assign gsh   = 22'((gprod + (58'sd1 <<< 35)) >>> 36);
   assign gsat  = (gsh > SAT_HI) ? SAT_HI : ((gsh < SAT_LO) ? SAT_LO : gsh);

   assign mix_sum = 17'(l_ff) + 17'(r_ff);
   assign mix_val = mix_sum[16:1];

   // ---------------- sequencer ----------------
   always_comb begin
      logic [24:0] ph;
      logic        fin;
      logic        rise;

      ph  = play_phase_ff;
      fin = finished_ff;
      rise = 1'b0;

      state_in      = state_ff;
      clr_addr_in   = clr_addr_ff;
      play_phase_in = play_phase_ff;
      prev_reset_in = prev_reset_ff;
      prev_mode_in  = prev_mode_ff;
      finished_in   = finished_ff;
      range_seen_in = range_seen_ff;
      prev_start_in = prev_start_ff;
      prev_end_in   = prev_end_ff;
      start_in      = start_ff;
      end_in        = end_ff;
      span_in       = span_ff;
      playing_in    = playing_ff;
      frames_in     = frames_ff;
      prod_in       = prod_ff;
      inc_in        = inc_ff;
      base_in       = base_ff;
      x_in          = x_ff;
      bounded_in    = bounded_ff;
      idx_in        = idx_ff;
      i1_in         = i1_ff;
      t_in          = t_ff;
      s0l_in        = s0l_ff;
      s0r_in        = s0r_ff;
      s1l_in        = s1l_ff;
      s1r_in        = s1r_ff;
      lv_in         = lv_ff;
      rv_in         = rv_ff;
      l_in          = l_ff;
      r_in          = r_ff;
      done_in       = done_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      rsp_last_in   = rsp_last_ff;

      req_tready = 1'b0;
      mem_we     = 1'b0;
      mem_waddr  = clr_addr_ff;
      mem_wl     = '0;
      mem_wr     = '0;
      mem_raddr  = i0[AW-1:0];
      div_start  = 1'b0;
      div_dvd    = '0;
      div_dvs    = '0;

      unique case (state_ff)
         // Zero both memories after reset
         isp_pkg::ST_CLEAR: begin
            mem_we      = 1'b1;
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == AW'(MAX_FRAMES - 1)) begin
               state_in = isp_pkg::ST_IDLE;
            end
         end

         // Take a request; a write finishes at once
         isp_pkg::ST_IDLE: begin
            req_tready = !rsp_valid_ff;
            if (req_acc) begin
               if (req_tuser == isp_pkg::CMD_WRITE) begin
                  mem_we    = ({1'b0, req_tdata[15:0]} < 17'(MAX_FRAMES));
                  mem_waddr = AW'(req_tdata[15:0]);
                  mem_wl    = req_tdata[31:16];
                  mem_wr    = req_tdata[47:32];
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = '0;
                  rsp_last_in  = 1'b0;
               end else begin
                  state_in = isp_pkg::ST_SETUP;
               end
            end
         end

         // Range, mode and rewind bookkeeping
         isp_pkg::ST_SETUP: begin
            if (!range_seen_ff) begin
               ph  = s_start;
               fin = 1'b0;
            end else if (prev_start_ff != s_start || prev_end_ff != s_end) begin
               if (ph < s_start || ph > s_end) begin
                  ph = s_start;
               end
               fin = 1'b0;
            end
            if (prev_mode_ff != in_mode_ff) begin
               fin = 1'b0;
            end
            rise = !prev_reset_ff && in_rst_ff;
            if (rise || in_mode_ff <= isp_pkg::MODE_STOP) begin
               ph  = s_start;
               fin = 1'b0;
            end
            range_seen_in = 1'b1;
            prev_start_in = s_start;
            prev_end_in   = s_end;
            prev_mode_in  = in_mode_ff;
            prev_reset_in = in_rst_ff;
            play_phase_in = ph;
            finished_in   = fin;
            playing_in    = (in_mode_ff >= isp_pkg::MODE_LOOP) && !fin;
            start_in      = s_start;
            end_in        = s_end;
            span_in       = s_end - s_start;
            frames_in     = frames_cl;
            l_in          = '0;
            r_in          = '0;
            bounded_in    = '0;
            done_in       = 1'b0;
            state_in = (frames_cl < FW'(2)) ? isp_pkg::ST_OUT : isp_pkg::ST_MUL;
         end

         isp_pkg::ST_MUL: begin
            prod_in  = in_speed_ff * $signed({1'b0, rate_ratio_ff});
            state_in = isp_pkg::ST_INC_GO;
         end

         // Increment magnitude over frames * 256
         isp_pkg::ST_INC_GO: begin
            div_start = 1'b1;
            div_dvd   = isp_pkg::DVD_W'(prod_ff < 0 ? -prod_ff : prod_ff);
            div_dvs   = isp_pkg::DVS_W'({frames_ff, 8'd0});
            state_in  = isp_pkg::ST_INC_WAIT;
         end

         isp_pkg::ST_INC_WAIT: begin
            if (div_done) begin
               inc_in   = (prod_ff < 0) ? -$signed({1'b0, div_quo[39:0]})
                                        : $signed({1'b0, div_quo[39:0]});
               state_in = isp_pkg::ST_POS_GO;
            end
         end

         // Bounded phase: floor modulo over the span
         isp_pkg::ST_POS_GO: begin
            base_in   = base_sel;
            x_in      = x_pos;
            div_start = 1'b1;
            div_dvd   = isp_pkg::DVD_W'(x_pos < 0 ? -x_pos : x_pos);
            div_dvs   = isp_pkg::DVS_W'(span_ff);
            state_in  = isp_pkg::ST_POS_WAIT;
         end

         isp_pkg::ST_POS_WAIT: begin
            if (div_done) begin
               bounded_in = mod_res;
               state_in   = playing_ff ? isp_pkg::ST_IDX : isp_pkg::ST_PHASE;
            end
         end

         isp_pkg::ST_IDX: begin
            idx_in   = bounded_ff * 47'(frm_m1);
            state_in = isp_pkg::ST_RD0;
         end

         // Read first frame, then the next one
         isp_pkg::ST_RD0: begin
            mem_raddr = i0[AW-1:0];
            i1_in     = ({1'b0, i0p1} < 24'(frames_ff)) ? AW'(i0p1) : AW'(frm_m1);
            t_in      = idx_cl[23:0];
            state_in  = isp_pkg::ST_RD1;
         end

         isp_pkg::ST_RD1: begin
            mem_raddr = i1_ff;
            s0l_in    = rdl_ff;
            s0r_in    = stereo_ff ? rdr_ff : rdl_ff;
            state_in  = isp_pkg::ST_RD2;
         end

         isp_pkg::ST_RD2: begin
            s1l_in   = rdl_ff;
            s1r_in   = stereo_ff ? rdr_ff : rdl_ff;
            state_in = isp_pkg::ST_INTL;
         end

         isp_pkg::ST_INTL: begin
            lv_in    = 41'(interp);
            state_in = isp_pkg::ST_INTR;
         end

         isp_pkg::ST_INTR: begin
            rv_in    = 41'(interp);
            state_in = isp_pkg::ST_GAINL;
         end

         isp_pkg::ST_GAINL: begin
            l_in     = 16'(gsat);
            state_in = isp_pkg::ST_GAINR;
         end

         isp_pkg::ST_GAINR: begin
            r_in     = 16'(gsat);
            state_in = isp_pkg::ST_PHASE;
         end

         // Advance, wrap or stop the free-running phase, or track the CV when connected
         isp_pkg::ST_PHASE: begin
            state_in = isp_pkg::ST_OUT;
            if (!in_conn_ff && playing_ff) begin
               if (in_mode_ff == isp_pkg::MODE_LOOP) begin
                  done_in   = (next_ph < $signed({16'd0, start_ff}))
                           || (next_ph >= $signed({16'd0, end_ff}));
                  x_in      = x_wrap;
                  div_start = 1'b1;
                  div_dvd   = isp_pkg::DVD_W'(x_wrap < 0 ? -x_wrap : x_wrap);
                  div_dvs   = isp_pkg::DVS_W'(span_ff);
                  state_in  = isp_pkg::ST_WRAP_WAIT;
               end else if (!in_speed_ff[25] && next_ph >= $signed({16'd0, end_ff})) begin
                  play_phase_in = end_ff;
                  finished_in   = 1'b1;
                  done_in       = 1'b1;
               end else if (in_speed_ff[25] && next_ph <= $signed({16'd0, start_ff})) begin
                  play_phase_in = start_ff;
                  finished_in   = 1'b1;
                  done_in       = 1'b1;
               end else if (next_ph > $signed({16'd0, end_ff})) begin
                  play_phase_in = end_ff;
               end else if (next_ph < $signed({16'd0, start_ff})) begin
                  play_phase_in = start_ff;
               end else begin
                  play_phase_in = next_ph[24:0];
               end
            end else if (!in_conn_ff && in_mode_ff <= isp_pkg::MODE_STOP) begin
               play_phase_in = start_ff;
            end else if (in_conn_ff) begin
               play_phase_in = cv_cl;
            end
         end

         isp_pkg::ST_WRAP_WAIT: begin
            if (div_done) begin
               play_phase_in = wrap_ph;
               state_in      = isp_pkg::ST_OUT;
            end
         end

         // Load the response register
         isp_pkg::ST_OUT: begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = {7'd0, bounded_ff, mix_val, r_ff, l_ff};
            rsp_last_in  = done_ff;
            state_in     = isp_pkg::ST_IDLE;
         end

         default: begin
            state_in = isp_pkg::ST_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= isp_pkg::ST_CLEAR;
         clr_addr_ff   <= '0;
         play_phase_ff <= '0;
         prev_reset_ff <= 1'b0;
         prev_mode_ff  <= isp_pkg::MODE_NONE;
         finished_ff   <= 1'b0;
         range_seen_ff <= 1'b0;
         prev_start_ff <= '0;
         prev_end_ff   <= isp_pkg::ONE_Q24;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_addr_ff   <= clr_addr_in;
         play_phase_ff <= play_phase_in;
         prev_reset_ff <= prev_reset_in;
         prev_mode_ff  <= prev_mode_in;
         finished_ff   <= finished_in;
         range_seen_ff <= range_seen_in;
         prev_start_ff <= prev_start_in;
         prev_end_ff   <= prev_end_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Work and payload registers
   always_ff @(posedge clock) begin
      start_ff    <= start_in;
      end_ff      <= end_in;
      span_ff     <= span_in;
      playing_ff  <= playing_in;
      frames_ff   <= frames_in;
      prod_ff     <= prod_in;
      inc_ff      <= inc_in;
      base_ff     <= base_in;
      x_ff        <= x_in;
      bounded_ff  <= bounded_in;
      idx_ff      <= idx_in;
      i1_ff       <= i1_in;
      t_ff        <= t_in;
      s0l_ff      <= s0l_in;
      s0r_ff      <= s0r_in;
      s1l_ff      <= s1l_in;
      s1r_ff      <= s1r_in;
      lv_ff       <= lv_in;
      rv_ff       <= rv_in;
      l_ff        <= l_in;
      r_ff        <= r_in;
      done_ff     <= done_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

FILE: design/isp_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isp_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module isp_div #(
   parameter int DVD_W = isp_pkg::DVD_W,
   parameter int DVS_W = isp_pkg::DVS_W
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DVD_W-1:0] dividend,
   input  logic [DVS_W-1:0] divisor,
   output logic             done,
   output logic [DVD_W-1:0] quotient,
   output logic [DVS_W-1:0] remainder
);

   localparam int CW = $clog2(DVD_W + 1);

   logic [CW-1:0]    cnt_ff;
   logic             busy_ff;
   logic             done_ff;
   logic [DVD_W-1:0] quo_ff;
   logic [DVS_W-1:0] rem_ff;
   logic [DVS_W-1:0] dvs_ff;
   logic [DVS_W:0]   trial;
   logic             fits;

   // Shift in the next dividend bit and try a subtract
   assign trial = {rem_ff, quo_ff[DVD_W-1]};
   assign fits  = trial >= {1'b0, dvs_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CW'(DVD_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         dvs_ff <= divisor;
      end else if (busy_ff) begin
         quo_ff <= {quo_ff[DVD_W-2:0], fits};
         rem_ff <= fits ? DVS_W'(trial - {1'b0, dvs_ff}) : trial[DVS_W-1:0];
      end
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule
